// ===== hw/rtl/rtdt_pkg.sv =====
// ----------------------------------------------------------------------------
// rtdt_pkg: shared types and constants for the run timer distance tracker
// Command codes, fixed-point widths, CORDIC arctangent table, radius reset.
// ----------------------------------------------------------------------------
package rtdt_pkg;

	localparam int TIME_BITS         = 48;
	localparam int CORDIC_ITERATIONS = 24;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [2:0]           cmd_t;
	typedef logic [23:0]          radius_t;

	localparam cmd_t CMD_START = 3'd0;
	localparam cmd_t CMD_PAUSE = 3'd1;
	localparam cmd_t CMD_STOP  = 3'd2;
	localparam cmd_t CMD_RESET = 3'd3;
	localparam cmd_t CMD_GPS   = 3'd4;

	localparam radius_t RADIUS_RESET = 24'd6371000;

	localparam int APB_AW = 3;

	// CORDIC datapath word and multiplier operand/product
	localparam int CW = 34;
	localparam int MW = 33;
	typedef logic signed [CW-1:0]   cval_t;
	typedef logic signed [MW-1:0]   mop_t;
	typedef logic signed [2*MW-1:0] mprod_t;

	// distance step in mm
	localparam int D_W = 38;
	typedef logic [D_W-1:0] step_t;

	typedef logic [4:0] iter_t;
	localparam iter_t ITER_LAST = iter_t'(CORDIC_ITERATIONS - 1);

	localparam cval_t ONE_Q30      = 34'sh0_4000_0000;
	localparam cval_t HALF_TURN    = 34'sh0_8000_0000;
	localparam cval_t INV_GAIN_Q30 = 34'sd652032874;
	// 2^64/3.6e9 rounded, minus 2^32
	localparam mop_t  TURN_FRAC    = 33'sd829128280;
	localparam mop_t  MM_FACTOR    = 33'sd3216991;

	typedef struct packed {
		logic start;
		logic vectoring;
	} cordic_req_t;

	function automatic cval_t atan_lut(input iter_t i);
		cval_t v;
		unique case (i)
			5'd0:  v = 34'sd536870912;
			5'd1:  v = 34'sd316933406;
			5'd2:  v = 34'sd167458907;
			5'd3:  v = 34'sd85004756;
			5'd4:  v = 34'sd42667331;
			5'd5:  v = 34'sd21354465;
			5'd6:  v = 34'sd10679838;
			5'd7:  v = 34'sd5340245;
			5'd8:  v = 34'sd2670163;
			5'd9:  v = 34'sd1335087;
			5'd10: v = 34'sd667544;
			5'd11: v = 34'sd333772;
			5'd12: v = 34'sd166886;
			5'd13: v = 34'sd83443;
			5'd14: v = 34'sd41722;
			5'd15: v = 34'sd20861;
			5'd16: v = 34'sd10430;
			5'd17: v = 34'sd5215;
			5'd18: v = 34'sd2608;
			5'd19: v = 34'sd1304;
			5'd20: v = 34'sd652;
			5'd21: v = 34'sd326;
			5'd22: v = 34'sd163;
			5'd23: v = 34'sd81;
			5'd24: v = 34'sd41;
			5'd25: v = 34'sd20;
			5'd26: v = 34'sd10;
			5'd27: v = 34'sd5;
			5'd28: v = 34'sd3;
			5'd29: v = 34'sd1;
			5'd30: v = 34'sd1;
			default: v = 34'sd0;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/rtdt_if.sv =====
// ----------------------------------------------------------------------------
// rtdt_if: command and status channels
// Valid/ready channels carrying one command or one status transaction.
// ----------------------------------------------------------------------------
interface rtdt_cmd_if;
	logic                valid;
	logic                ready;
	rtdt_pkg::cmd_t      cmd;
	logic [47:0]         now_us;
	logic signed [30:0]  latitude;
	logic signed [31:0]  longitude;

	modport source (output valid, cmd, now_us, latitude, longitude, input ready);
	modport sink   (input valid, cmd, now_us, latitude, longitude, output ready);
	modport monitor (input valid, ready, cmd, now_us, latitude, longitude);
endinterface

interface rtdt_status_if;
	logic        valid;
	logic        ready;
	logic        running;
	logic        on_hold;
	logic [47:0] active_us;
	logic [47:0] distance_mm;

	modport source (output valid, running, on_hold, active_us, distance_mm, input ready);
	modport sink   (input valid, running, on_hold, active_us, distance_mm, output ready);
	modport monitor (input valid, ready, running, on_hold, active_us, distance_mm);
endinterface

// ===== hw/rtl/rtdt_cordic.sv =====
// ----------------------------------------------------------------------------
// rtdt_cordic: shared iterative CORDIC
// One micro-rotation per cycle, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module rtdt_cordic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rtdt_pkg::cordic_req_t req,
	input  rtdt_pkg::cval_t       x0,
	input  rtdt_pkg::cval_t       y0,
	input  rtdt_pkg::cval_t       z0,
	output logic                  busy,
	output rtdt_pkg::cval_t       x,
	output rtdt_pkg::cval_t       y,
	output rtdt_pkg::cval_t       z
);
	logic            busy_q;
	logic            vec_q;
	rtdt_pkg::iter_t cnt_q;
	rtdt_pkg::cval_t x_q, y_q, z_q;
	rtdt_pkg::cval_t dx, dy, ang;
	logic            up;

	always_comb begin
		dx  = y_q >>> cnt_q;
		dy  = x_q >>> cnt_q;
		ang = rtdt_pkg::atan_lut(cnt_q);
		// rotation drives z to zero, vectoring drives y to zero
		up  = vec_q ? y_q[rtdt_pkg::CW-1] : !z_q[rtdt_pkg::CW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			vec_q  <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			vec_q  <= req.vectoring;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == rtdt_pkg::ITER_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (up) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ang;
			end
		end
	end

	assign busy = busy_q;
	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;
endmodule

// ===== hw/rtl/rtdt_isqrt.sv =====
// ----------------------------------------------------------------------------
// rtdt_isqrt: iterative integer square root
// Digit-by-digit floor square root of a 61-bit value, one digit per cycle.
// ----------------------------------------------------------------------------
module rtdt_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [60:0] n,
	output logic        busy,
	output logic [30:0] root
);
	logic        busy_q;
	logic [60:0] rem_q;
	logic [61:0] r_q;
	logic [60:0] bit_q;
	logic [61:0] trial;
	logic        take;

	always_comb begin
		trial = r_q + 62'(bit_q);
		take  = 62'(rem_q) >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= n;
			r_q   <= '0;
			bit_q <= 61'(1) << 60;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= 61'(62'(rem_q) - trial);
				r_q   <= (r_q >> 1) + 62'(bit_q);
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = r_q[30:0];
endmodule

// ===== hw/rtl/rtdt_dist.sv =====
// ----------------------------------------------------------------------------
// rtdt_dist: haversine step sequencer
// Drives the shared CORDIC, square root unit and multiplier to get one step.
// ----------------------------------------------------------------------------
module rtdt_dist (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [31:0]    lat_cur,
	input  logic signed [31:0]    lon_cur,
	input  logic signed [31:0]    lat_prev,
	input  logic signed [31:0]    lon_prev,
	input  rtdt_pkg::radius_t     radius,
	output logic                  done,
	output rtdt_pkg::step_t       step_mm
);
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_TA   = 5'd1;
	localparam logic [4:0] S_TB   = 5'd2;
	localparam logic [4:0] S_RA   = 5'd3;
	localparam logic [4:0] S_RW   = 5'd4;
	localparam logic [4:0] S_M1   = 5'd5;
	localparam logic [4:0] S_M2   = 5'd6;
	localparam logic [4:0] S_M3   = 5'd7;
	localparam logic [4:0] S_M4   = 5'd8;
	localparam logic [4:0] S_M5   = 5'd9;
	localparam logic [4:0] S_QA   = 5'd10;
	localparam logic [4:0] S_QW   = 5'd11;
	localparam logic [4:0] S_VA   = 5'd12;
	localparam logic [4:0] S_VW   = 5'd13;
	localparam logic [4:0] S_P1   = 5'd14;
	localparam logic [4:0] S_P2   = 5'd15;
	localparam logic [4:0] S_P3   = 5'd16;
	localparam logic [4:0] S_P4   = 5'd17;

	logic [4:0]             state_q;
	logic [1:0]             sel_q;
	logic signed [31:0]     coord_q [4];
	logic [31:0]            turn_q  [4];
	logic                   rneg_q;
	rtdt_pkg::mop_t         s1_q, s2_q, c1_q, c2_q, s1sq_q, s2sq_q;
	logic [30:0]            a_q, ry_q, rx_q;
	logic [31:0]            z_q;
	logic [18:0]            qh_q;
	logic [41:0]            lo_q;
	rtdt_pkg::mprod_t       prod_q;
	rtdt_pkg::step_t        step_q;
	logic                   done_q;

	rtdt_pkg::mop_t         mul_a, mul_b;
	rtdt_pkg::cordic_req_t  creq;
	rtdt_pkg::cval_t        cx0, cy0, cz0, cx, cy, cz;
	logic                   cbusy;
	logic                   sq_start, sq_busy;
	logic [60:0]            sq_n;
	logic [30:0]            sq_root;

	logic signed [31:0]     csel;
	logic                   cneg;
	rtdt_pkg::mop_t         mag;
	logic [63:0]            rnd;
	logic [31:0]            pmag, turn_new;
	logic [31:0]            hdlat, hdlon, ang;
	rtdt_pkg::cval_t        zs, zf;
	logic                   zneg;
	rtdt_pkg::cval_t        rx_sel, ry_sel;
	rtdt_pkg::cval_t        asum;
	logic [38:0]            qv;
	logic [61:0]            fsum;

	rtdt_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.x0     (cx0),
		.y0     (cy0),
		.z0     (cz0),
		.busy   (cbusy),
		.x      (cx),
		.y      (cy),
		.z      (cz)
	);

	rtdt_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.n      (sq_n),
		.busy   (sq_busy),
		.root   (sq_root)
	);

	// coordinate to binary angle: m * 2^32 + m * frac, rounded
	always_comb begin
		csel     = coord_q[sel_q];
		cneg     = csel[31];
		mag      = cneg ? -rtdt_pkg::mop_t'(csel) : rtdt_pkg::mop_t'(csel);
		rnd      = prod_q[63:0] + 64'h0000_0000_8000_0000;
		pmag     = mag[31:0] + rnd[63:32];
		turn_new = cneg ? -pmag : pmag;
	end

	// angle for the rotation pass, folded to [-90, 90] degrees
	always_comb begin
		hdlat = (turn_q[0] - turn_q[1]) >> 1;
		hdlon = (turn_q[2] - turn_q[3]) >> 1;
		unique case (sel_q)
			2'd0:    ang = hdlat;
			2'd1:    ang = hdlon;
			2'd2:    ang = turn_q[0];
			default: ang = turn_q[1];
		endcase
		zs   = rtdt_pkg::cval_t'($signed(ang));
		zf   = zs;
		zneg = 1'b0;
		if (zs > rtdt_pkg::ONE_Q30) begin
			zf   = zs - rtdt_pkg::HALF_TURN;
			zneg = 1'b1;
		end else if (zs < -rtdt_pkg::ONE_Q30) begin
			zf   = zs + rtdt_pkg::HALF_TURN;
			zneg = 1'b1;
		end
		rx_sel = rneg_q ? -cx : cx;
		ry_sel = rneg_q ? -cy : cy;
		asum   = rtdt_pkg::cval_t'(s1sq_q) + rtdt_pkg::cval_t'(prod_q >>> 30);
		qv     = prod_q[54:16];
		fsum   = {prod_q[41:0], 20'b0} + 62'(lo_q);
	end

	// shared unit control and multiplier operands
	always_comb begin
		creq     = '0;
		cx0      = rtdt_pkg::INV_GAIN_Q30;
		cy0      = '0;
		cz0      = zf;
		sq_start = 1'b0;
		sq_n     = (sel_q == 2'd0) ? {a_q, 30'b0} : {31'(32'h4000_0000 - 32'(a_q)), 30'b0};
		mul_a    = mag;
		mul_b    = rtdt_pkg::TURN_FRAC;
		unique case (state_q)
			S_RA: begin
				creq.start = 1'b1;
			end
			S_QA: begin
				sq_start = 1'b1;
			end
			S_VA: begin
				creq.start     = 1'b1;
				creq.vectoring = 1'b1;
				cx0            = rtdt_pkg::cval_t'({1'b0, rx_q});
				cy0            = rtdt_pkg::cval_t'({1'b0, ry_q});
				cz0            = '0;
			end
			S_M1: begin
				mul_a = s1_q;
				mul_b = s1_q;
			end
			S_M2: begin
				mul_a = s2_q;
				mul_b = s2_q;
			end
			S_M3: begin
				mul_a = c1_q;
				mul_b = c2_q;
			end
			S_M4: begin
				mul_a = s2sq_q;
				mul_b = rtdt_pkg::mop_t'(prod_q >>> 30);
			end
			S_P1: begin
				mul_a = $signed({9'b0, radius});
				mul_b = $signed({1'b0, z_q});
			end
			S_P2: begin
				mul_a = $signed({13'b0, qv[19:0]});
				mul_b = rtdt_pkg::MM_FACTOR;
			end
			S_P3: begin
				mul_a = $signed({14'b0, qh_q});
				mul_b = rtdt_pkg::MM_FACTOR;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_TA;
					sel_q   <= '0;
				end
				S_TA: state_q <= S_TB;
				S_TB: begin
					sel_q   <= sel_q + 2'd1;
					state_q <= (sel_q == 2'd3) ? S_RA : S_TA;
				end
				S_RA: state_q <= S_RW;
				S_RW: if (!cbusy) begin
					sel_q   <= sel_q + 2'd1;
					state_q <= (sel_q == 2'd3) ? S_M1 : S_RA;
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: state_q <= S_M5;
				S_M5: begin
					state_q <= S_QA;
					sel_q   <= '0;
				end
				S_QA: state_q <= S_QW;
				S_QW: if (!sq_busy) begin
					sel_q   <= sel_q + 2'd1;
					state_q <= (sel_q == 2'd1) ? S_VA : S_QA;
				end
				S_VA: state_q <= S_VW;
				S_VW: if (!cbusy) begin
					state_q <= S_P1;
				end
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_P3;
				S_P3: state_q <= S_P4;
				S_P4: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			coord_q[0] <= lat_cur;
			coord_q[1] <= lat_prev;
			coord_q[2] <= lon_cur;
			coord_q[3] <= lon_prev;
		end
		if (state_q == S_TB) begin
			turn_q[sel_q] <= turn_new;
		end
		if (state_q == S_RA) begin
			rneg_q <= zneg;
		end
		if (state_q == S_RW && !cbusy) begin
			unique case (sel_q)
				2'd0:    s1_q <= rtdt_pkg::mop_t'(ry_sel);
				2'd1:    s2_q <= rtdt_pkg::mop_t'(ry_sel);
				2'd2:    c1_q <= rtdt_pkg::mop_t'(rx_sel);
				default: c2_q <= rtdt_pkg::mop_t'(rx_sel);
			endcase
		end
		if (state_q == S_M2) begin
			s1sq_q <= rtdt_pkg::mop_t'(prod_q >>> 30);
		end
		if (state_q == S_M3) begin
			s2sq_q <= rtdt_pkg::mop_t'(prod_q >>> 30);
		end
		if (state_q == S_M5) begin
			if (asum < 0) begin
				a_q <= '0;
			end else if (asum > rtdt_pkg::ONE_Q30) begin
				a_q <= 31'h4000_0000;
			end else begin
				a_q <= asum[30:0];
			end
		end
		if (state_q == S_QW && !sq_busy) begin
			if (sel_q == 2'd0) begin
				ry_q <= sq_root;
			end else begin
				rx_q <= sq_root;
			end
		end
		if (state_q == S_VW && !cbusy) begin
			z_q <= cz[rtdt_pkg::CW-1] ? 32'd0 : cz[31:0];
		end
		if (state_q == S_P2) begin
			qh_q <= qv[38:20];
		end
		if (state_q == S_P3) begin
			lo_q <= prod_q[41:0];
		end
		if (state_q == S_P4) begin
			step_q <= fsum[61:24];
		end
	end

	assign done    = done_q;
	assign step_mm = step_q;
endmodule

// ===== hw/rtl/run_timer_distance_tracker.sv =====
// ----------------------------------------------------------------------------
// run_timer_distance_tracker: stopwatch with pause and distance accumulator
// Keeps active run time and sums haversine steps between GPS points.
// ----------------------------------------------------------------------------
// Start, pause, stop, reset, ignored points and the first point of a run
//   give their status transaction in the cycle after acceptance.
// A counted GPS point gives its status once its step is done, computed by the
//   shared CORDIC unit (five passes of 24 iterations) and two 31-step square roots.
// One command in flight at a time; the next is taken in the cycle its status is taken.
// Reset (arst_n low) clears all run state and loads the default radius.
module run_timer_distance_tracker (
	input  logic                              clk,
	input  logic                              arst_n,
	rtdt_cmd_if.sink                          cmd_ch,
	rtdt_status_if.source                     status_ch,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rtdt_pkg::APB_AW-1:0]       paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	// architectural run state
	logic                  run_q, pause_q, have_q;
	rtdt_pkg::time_t       first_q, banked_q, ptot_q, lstart_q, lpause_q;
	logic signed [31:0]    plat_q, plon_q;
	logic [47:0]           dist_q;
	rtdt_pkg::radius_t     radius_q;
	logic                  busy_q;

	// status output register
	logic                  ovalid_q, orun_q, opause_q;
	logic [47:0]           oact_q, odist_q;

	// next state for the accepted command
	logic                  n_run, n_pause, n_have;
	rtdt_pkg::time_t       n_first, n_banked, n_ptot, n_lstart, n_lpause;
	logic signed [31:0]    n_plat, n_plon;
	logic [47:0]           n_dist;
	rtdt_pkg::time_t       now_t, act;
	logic                  gps_go;
	logic                  accept, cfg_wr;

	logic                  step_done;
	rtdt_pkg::step_t       step_mm;
	logic [48:0]           dsum;
	logic [47:0]           dsat;

	assign pready          = 1'b1;
	assign cfg_wr          = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign prdata          = (paddr[2] == 1'b0) ? {8'b0, radius_q} : 32'd0;

	// take a command only when idle and the status slot is free or draining
	assign cmd_ch.ready    = !busy_q && (!ovalid_q || status_ch.ready);
	assign accept          = cmd_ch.valid && cmd_ch.ready;
	assign now_t           = rtdt_pkg::time_t'(cmd_ch.now_us);

	always_comb begin
		n_run    = run_q;
		n_pause  = pause_q;
		n_have   = have_q;
		n_first  = first_q;
		n_banked = banked_q;
		n_ptot   = ptot_q;
		n_lstart = lstart_q;
		n_lpause = lpause_q;
		n_plat   = plat_q;
		n_plon   = plon_q;
		n_dist   = dist_q;
		gps_go   = 1'b0;
		unique case (cmd_ch.cmd)
			rtdt_pkg::CMD_START: begin
				n_run   = 1'b1;
				n_pause = 1'b0;
				// fresh run: restart the clock base
				if (banked_q == '0) begin
					n_first  = now_t;
					n_lpause = now_t;
				end
				n_lstart = now_t;
				n_ptot   = ptot_q + now_t - n_lpause;
			end
			rtdt_pkg::CMD_PAUSE: begin
				n_pause  = 1'b1;
				n_lpause = now_t;
				n_banked = banked_q + now_t - lstart_q;
			end
			rtdt_pkg::CMD_STOP: begin
				if (!pause_q) begin
					n_pause  = 1'b1;
					n_lpause = now_t;
					n_banked = banked_q + now_t - lstart_q;
				end
				n_run = 1'b0;
			end
			rtdt_pkg::CMD_RESET: begin
				n_run    = 1'b0;
				n_pause  = 1'b1;
				n_have   = 1'b0;
				n_first  = '0;
				n_banked = '0;
				n_ptot   = '0;
				n_lstart = '0;
				n_lpause = '0;
				n_plat   = '0;
				n_plon   = '0;
				n_dist   = '0;
			end
			rtdt_pkg::CMD_GPS: begin
				// count points only in an active, unpaused run
				if (run_q && !pause_q) begin
					n_have = 1'b1;
					n_plat = 32'(cmd_ch.latitude);
					n_plon = cmd_ch.longitude;
					gps_go = have_q;
				end
			end
			default: ;
		endcase
		act = (n_run && !n_pause) ? (now_t - n_first - n_ptot) : n_banked;
	end

	rtdt_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && gps_go),
		.lat_cur  (32'(cmd_ch.latitude)),
		.lon_cur  (cmd_ch.longitude),
		.lat_prev (plat_q),
		.lon_prev (plon_q),
		.radius   (radius_q),
		.done     (step_done),
		.step_mm  (step_mm)
	);

	// saturate the running distance at full scale
	assign dsum = {1'b0, dist_q} + 49'(step_mm);
	assign dsat = dsum[48] ? '1 : dsum[47:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			pause_q  <= 1'b1;
			have_q   <= 1'b0;
			first_q  <= '0;
			banked_q <= '0;
			ptot_q   <= '0;
			lstart_q <= '0;
			lpause_q <= '0;
			plat_q   <= '0;
			plon_q   <= '0;
			dist_q   <= '0;
			radius_q <= rtdt_pkg::RADIUS_RESET;
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				radius_q <= pwdata[23:0];
			end
			// drop the status once taken
			if (ovalid_q && status_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			if (accept) begin
				run_q    <= n_run;
				pause_q  <= n_pause;
				have_q   <= n_have;
				first_q  <= n_first;
				banked_q <= n_banked;
				ptot_q   <= n_ptot;
				lstart_q <= n_lstart;
				lpause_q <= n_lpause;
				plat_q   <= n_plat;
				plon_q   <= n_plon;
				dist_q   <= n_dist;
				if (gps_go) begin
					busy_q <= 1'b1;
				end else begin
					ovalid_q <= 1'b1;
				end
			end
			if (step_done) begin
				dist_q   <= dsat;
				busy_q   <= 1'b0;
				ovalid_q <= 1'b1;
			end
		end
	end

	// status payload: timing fields load at acceptance, distance when known
	always_ff @(posedge clk) begin
		if (accept) begin
			orun_q   <= n_run;
			opause_q <= n_pause;
			oact_q   <= 48'(act);
			odist_q  <= n_dist;
		end
		if (step_done) begin
			odist_q <= dsat;
		end
	end

	assign status_ch.valid       = ovalid_q;
	assign status_ch.running     = orun_q;
	assign status_ch.on_hold     = opause_q;
	assign status_ch.active_us   = oact_q;
	assign status_ch.distance_mm = odist_q;
endmodule

// ===== hw/rtl/rtdt_checker.sv =====
// ----------------------------------------------------------------------------
// rtdt_checker: port-level checks for the run timer distance tracker
// Watches the command and status channels and flags protocol or state slips.
// ----------------------------------------------------------------------------
module rtdt_checker (
	input  logic              clk,
	input  logic              arst_n,
	rtdt_cmd_if.sink          cmd_ch,
	rtdt_status_if.source     status_ch
);
	// hold a stalled status transaction
	a_status_hold: assert property (@(posedge clk) disable iff (!arst_n)
		status_ch.valid && !status_ch.ready |=> status_ch.valid &&
		$stable(status_ch.distance_mm) && $stable(status_ch.active_us))
		else $error("status transaction changed while stalled");

	// no new command while a status result is stuck
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		status_ch.valid && !status_ch.ready |-> !cmd_ch.ready)
		else $error("command taken while status stalled");

	// reset command clears the run and the distance at once
	a_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ch.valid && cmd_ch.ready && cmd_ch.cmd == rtdt_pkg::CMD_RESET |=>
		status_ch.valid && !status_ch.running && status_ch.on_hold &&
		status_ch.distance_mm == 48'd0 && status_ch.active_us == 48'd0)
		else $error("reset command did not clear state");

	// an unpaused status only occurs inside a run
	a_unpaused_running: assert property (@(posedge clk) disable iff (!arst_n)
		status_ch.valid && !status_ch.on_hold |-> status_ch.running)
		else $error("unpaused status outside a run");
endmodule

bind run_timer_distance_tracker rtdt_checker u_rtdt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_ch    (cmd_ch),
	.status_ch (status_ch)
);
